// File: design/rrrob_pkg.sv
// Package: shared types and constants of the register rename reorder buffer.
package rrrob_pkg;

	localparam int BufferDepthDef = 64;
	localparam int ArchRegsDef    = 128;

	typedef enum logic [1:0] {
		OP_RENAME   = 2'd0,
		OP_COMPLETE = 2'd1,
		OP_RETIRE   = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_RDY  = 2'd2,
		ST_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_READ = 2'd1,
		FSM_LOOK = 2'd2,
		FSM_EXEC = 2'd3
	} fsm_t;

endpackage

// File: design/rrrob_map.sv
// Map table: per-register valid bits and a tag memory with two read ports.
module rrrob_map #(
	parameter int ArchRegs = rrrob_pkg::ArchRegsDef,
	parameter int TagW     = $clog2(rrrob_pkg::BufferDepthDef)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(ArchRegs)-1:0] rd_a,
	input  logic [$clog2(ArchRegs)-1:0] rd_b,
	output logic                        vld_a,
	output logic                        vld_b,
	output logic [TagW-1:0]             tag_a,
	output logic [TagW-1:0]             tag_b,
	input  logic                        set_en,
	input  logic [$clog2(ArchRegs)-1:0] set_reg,
	input  logic [TagW-1:0]             set_tag,
	input  logic                        clr_en,
	input  logic [$clog2(ArchRegs)-1:0] clr_reg
);
	logic [TagW-1:0]     mem [ArchRegs];
	logic [ArchRegs-1:0] valid_q;

	// Tag memory: registered reads
	always_ff @(posedge clk) begin
		if (set_en) begin
			mem[set_reg] <= set_tag;
		end
		tag_a <= mem[rd_a];
		tag_b <= mem[rd_b];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clr_en) begin
				valid_q[clr_reg] <= 1'b0;
			end
			if (set_en) begin
				valid_q[set_reg] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_a <= valid_q[rd_a];
		vld_b <= valid_q[rd_b];
	end
endmodule

// File: design/rrrob_buf.sv
// Reorder buffer entries: busy/done flags and destination memory.
module rrrob_buf #(
	parameter int Depth = rrrob_pkg::BufferDepthDef,
	parameter int RegW  = $clog2(rrrob_pkg::ArchRegsDef)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(Depth)-1:0] rd_a,
	input  logic [$clog2(Depth)-1:0] rd_b,
	output logic                     busy_a,
	output logic                     done_a,
	output logic                     busy_b,
	output logic                     done_b,
	input  logic [$clog2(Depth)-1:0] rd_h,
	output logic                     hd_h,
	output logic [RegW-1:0]          dreg_h,
	input  logic                     alloc_en,
	input  logic [$clog2(Depth)-1:0] alloc_idx,
	input  logic                     alloc_hd,
	input  logic [RegW-1:0]          alloc_reg,
	input  logic                     done_en,
	input  logic [$clog2(Depth)-1:0] done_idx,
	input  logic                     free_en,
	input  logic [$clog2(Depth)-1:0] free_idx
);
	logic [RegW:0]    dmem [Depth];
	logic [Depth-1:0] busy_q;
	logic [Depth-1:0] done_q;

	// Destination memory
	always_ff @(posedge clk) begin
		if (alloc_en) begin
			dmem[alloc_idx] <= {alloc_hd, alloc_reg};
		end
		{hd_h, dreg_h} <= dmem[rd_h];
	end

	// Entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			done_q <= '0;
		end else begin
			if (done_en) begin
				done_q[done_idx] <= 1'b1;
			end
			if (free_en) begin
				busy_q[free_idx] <= 1'b0;
				done_q[free_idx] <= 1'b0;
			end
			if (alloc_en) begin
				busy_q[alloc_idx] <= 1'b1;
				done_q[alloc_idx] <= 1'b0;
			end
		end
	end

	// Registered flag reads
	always_ff @(posedge clk) begin
		busy_a <= busy_q[rd_a];
		done_a <= done_q[rd_a];
		busy_b <= busy_q[rd_b];
		done_b <= done_q[rd_b];
	end
endmodule

// File: design/register_rename_reorder_buffer.sv
// Top level: register rename map with a circular reorder buffer.
// One word is handled at a time. It is captured when accepted; the next cycle
// reads the map at both sources and the destination memory at the head; the
// cycle after reads the entry flags of the looked-up tags (or of done_tag or
// the head) and, for a retire, the map at the head's destination; the execute
// cycle writes back and loads the result register. The result turns valid in
// the same cycle as the input opens again; the two dependent synchronous memory
// reads set the length of this sequence. A result held by out_stall keeps the
// following word in its write-back cycle until the output register frees. The
// entry count written through cfg_wdata sets the wrap point of head and tail
// (0 acts as 1, above the depth as the depth); write it only while no word is
// in flight. ARCH_REGS is taken as a power of two.
module register_rename_reorder_buffer #(
	parameter int BUFFER_DEPTH = rrrob_pkg::BufferDepthDef,
	parameter int ARCH_REGS    = rrrob_pkg::ArchRegsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic        dest_present,
	input  logic [6:0]  dest_reg,
	input  logic        src1_present,
	input  logic [6:0]  src1_reg,
	input  logic        src2_present,
	input  logic [6:0]  src2_reg,
	input  logic [5:0]  done_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  tag,
	output logic        src1_from_buffer,
	output logic [5:0]  src1_tag,
	output logic        src1_avail,
	output logic        src2_from_buffer,
	output logic [5:0]  src2_tag,
	output logic        src2_avail,
	output logic        retired_has_dest,
	output logic [6:0]  retired_dest_reg
);
	import rrrob_pkg::*;

	localparam int PW = $clog2(BUFFER_DEPTH);
	localparam int RW = $clog2(ARCH_REGS);

	fsm_t          state_q, state_d;
	logic [6:0]    entries_q;
	logic [PW-1:0] head_q, tail_q, size_m1, head_nx, tail_nx;
	logic          full_q;

	op_t           op_s1;
	logic          dp_s1, s1p_s1, s2p_s1;
	logic [RW-1:0] dr_s1, r1_s1, r2_s1;
	logic [5:0]    dt_s1;

	logic          v1, v2;
	logic [PW-1:0] t1, t2;
	logic          b1, d1, b2, d2, hdh;
	logic [RW-1:0] drh;

	logic [RW-1:0] map_rd_a;
	logic [PW-1:0] flag_rd_a;
	logic          accept, commit, out_free, ovalid_q;
	logic          alloc_en, done_en, free_en, clr_en;
	logic          dt_ok;
	logic [PW-1:0] dt_idx;
	logic          src1_hit, src2_hit;

	assign accept   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;

	// Active size minus one, clamped
	always_comb begin
		if (entries_q == 7'd0) begin
			size_m1 = '0;
		end else if (32'(entries_q) > BUFFER_DEPTH) begin
			size_m1 = PW'(BUFFER_DEPTH - 1);
		end else begin
			size_m1 = PW'(entries_q - 7'd1);
		end
	end

	assign tail_nx = (tail_q >= size_m1) ? '0 : tail_q + PW'(1);
	assign head_nx = (head_q >= size_m1) ? '0 : head_q + PW'(1);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; write-back waits for a free output register unless the op is OP_NONE
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		commit   = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = FSM_READ;
			end
			FSM_READ: state_d = FSM_LOOK;
			FSM_LOOK: state_d = FSM_EXEC;
			FSM_EXEC: begin
				if (op_s1 == OP_NONE || out_free) begin
					commit  = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default:  state_d = FSM_IDLE;
		endcase
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(op);
			dp_s1  <= dest_present;
			dr_s1  <= RW'(dest_reg);
			s1p_s1 <= src1_present;
			r1_s1  <= RW'(src1_reg);
			s2p_s1 <= src2_present;
			r2_s1  <= RW'(src2_reg);
			dt_s1  <= done_tag;
		end
	end

	// Complete tag range check
	assign dt_ok  = (32'(dt_s1) < BUFFER_DEPTH);
	assign dt_idx = PW'(dt_s1);

	// Map port a serves source 1, or the head's destination on retire
	assign map_rd_a = (op_s1 == OP_RETIRE) ? drh : r1_s1;

	// Flag port a: source 1 producer, done_tag or head
	always_comb begin
		case (op_s1)
			OP_COMPLETE: flag_rd_a = dt_idx;
			OP_RETIRE:   flag_rd_a = head_q;
			default:     flag_rd_a = t1;
		endcase
	end

	rrrob_map #(.ArchRegs(ARCH_REGS), .TagW(PW)) u_map (
		.clk, .arst_n,
		.rd_a(map_rd_a), .rd_b(r2_s1),
		.vld_a(v1), .vld_b(v2),
		.tag_a(t1), .tag_b(t2),
		.set_en(alloc_en && dp_s1), .set_reg(dr_s1), .set_tag(tail_q),
		.clr_en, .clr_reg(drh)
	);

	rrrob_buf #(.Depth(BUFFER_DEPTH), .RegW(RW)) u_buf (
		.clk, .arst_n,
		.rd_a(flag_rd_a), .rd_b(t2),
		.busy_a(b1), .done_a(d1), .busy_b(b2), .done_b(d2),
		.rd_h(head_q), .hd_h(hdh), .dreg_h(drh),
		.alloc_en, .alloc_idx(tail_q), .alloc_hd(dp_s1), .alloc_reg(dr_s1),
		.done_en, .done_idx(dt_idx),
		.free_en, .free_idx(head_q)
	);

	// Write-back decisions in the execute cycle
	always_comb begin
		alloc_en = commit && (op_s1 == OP_RENAME) && !full_q;
		done_en  = commit && (op_s1 == OP_COMPLETE) && dt_ok && b1;
		free_en  = commit && (op_s1 == OP_RETIRE) && b1 && d1;
		clr_en   = free_en && hdh && v1 && (t1 == head_q);
	end

	assign src1_hit = s1p_s1 && v1;
	assign src2_hit = s2p_s1 && v2;

	// Configuration, pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= 7'd64;
			head_q    <= '0;
			tail_q    <= '0;
			full_q    <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (alloc_en) begin
				tail_q <= tail_nx;
				if (tail_nx == head_q) begin
					full_q <= 1'b1;
				end
			end
			if (free_en) begin
				head_q <= head_nx;
				full_q <= 1'b0;
			end
			if (commit && op_s1 != OP_NONE) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (commit && op_s1 != OP_NONE) begin
			status           <= ST_DONE;
			tag              <= '0;
			src1_from_buffer <= 1'b0;
			src1_tag         <= '0;
			src1_avail       <= 1'b0;
			src2_from_buffer <= 1'b0;
			src2_tag         <= '0;
			src2_avail       <= 1'b0;
			retired_has_dest <= 1'b0;
			retired_dest_reg <= '0;
			case (op_s1)
				OP_RENAME: begin
					if (full_q) begin
						status <= ST_FULL;
					end else begin
						tag              <= 6'(tail_q);
						src1_from_buffer <= src1_hit;
						src1_tag         <= src1_hit ? 6'(t1) : 6'd0;
						src1_avail       <= !src1_hit || !b1 || d1;
						src2_from_buffer <= src2_hit;
						src2_tag         <= src2_hit ? 6'(t2) : 6'd0;
						src2_avail       <= !src2_hit || !b2 || d2;
					end
				end
				OP_COMPLETE: begin
					tag    <= dt_s1;
					status <= (dt_ok && b1) ? ST_DONE : ST_NOT_USED;
				end
				OP_RETIRE: begin
					tag <= 6'(head_q);
					if (!(b1 && d1)) begin
						status <= ST_NOT_RDY;
					end else begin
						retired_has_dest <= hdh;
						retired_dest_reg <= hdh ? 7'(drh) : 7'd0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(tag)))
		else $error("stalled result word changed");
	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({alloc_en, done_en, free_en}))
		else $error("two writes in one cycle");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |-> free_en)
		else $error("unmap without retire");
	a_full_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (head_q == tail_q))
		else $error("full with head and tail apart");
`endif
endmodule
